/* hw/rtl/cordic_sc_pkg.sv */
package cordic_sc_pkg;

   // Field and datapath widths.
   localparam int ANGLE_W = 32;
   localparam int OUT_W = 18;
   localparam int DATA_W = 20;
   localparam int REM_W = 31;
   localparam int PHASE_W = 19;
   localparam int QUOT_BITS = 13;
   localparam int TAB_LEN = 18;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [ANGLE_W:0] wide_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [OUT_W-1:0] out_type;
   typedef logic [REM_W-1:0] rem_type;

   // How an angle is brought back into [-pi, pi].
   typedef enum logic [1:0] {
      FOLD_PASS = 2'd0,
      FOLD_POS = 2'd1,
      FOLD_NEG = 2'd2
   } fold_type;

   // Fixed-point constants, 65536 = 1.0.
   localparam data_type INV_K = 20'sh09B74;
   localparam data_type HALF_PI = 20'sh1921F;
   localparam data_type PI_FX = 20'sh3243F;
   localparam int unsigned TWO_PI_INT = 32'd411774;

   // Arctangent of 2^-k, one entry per rotation step.
   localparam data_type ATAN_TAB [TAB_LEN] = '{
      20'sh0C90F, 20'sh076B1, 20'sh03EB6, 20'sh01FD5,
      20'sh00FFA, 20'sh007FF, 20'sh003FF, 20'sh001FF,
      20'sh000FF, 20'sh0007F, 20'sh0003F, 20'sh0001F,
      20'sh0000F, 20'sh00007, 20'sh00003, 20'sh00001,
      20'sh00000, 20'sh00000
   };

endpackage

/* hw/rtl/cordic_sine_cosine.sv */
// Sine and cosine of a signed 16.16 angle in radians, returned as signed 2.16 in
// 18 bits. The angle is reduced modulo 2*pi into [-pi, pi], reflected into
// [-pi/2, pi/2] (a reflection negates the cosine), then rotated by ITERATIONS
// CORDIC stages. The pipeline takes one word per clock unless stalled and holds
// nothing between words. Its registers are one entry stage, 13 remainder stages
// that each strip one quotient bit of the 2*pi reduction, one fold stage, one
// stage per rotation and the output register. A stall on the result side holds
// only the stages that are full, so bubbles close up before the input is held off.
module cordic_sine_cosine #(
   parameter int ITERATIONS = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cordic_sc_pkg::angle_type req_angle,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cordic_sc_pkg::out_type   rsp_sine,
   output cordic_sc_pkg::out_type   rsp_cosine
);
   import cordic_sc_pkg::*;

   logic     red_ready;
   logic     red_valid;
   data_type red_angle;
   logic     red_refl;
   logic     rot_ready;

   // Range reduction and reflection.
   cordic_sc_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (red_ready),
      .in_angle  (req_angle),
      .out_valid (red_valid),
      .out_ready (rot_ready),
      .out_angle (red_angle),
      .out_refl  (red_refl)
   );

   // Rotation stages and output register.
   cordic_sc_rotate #(
      .ITERATIONS (ITERATIONS)
   ) u_rotate (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (red_valid),
      .in_ready   (rot_ready),
      .in_angle   (red_angle),
      .in_refl    (red_refl),
      .out_valid  (rsp_valid),
      .out_ready  (!rsp_stall),
      .out_sine   (rsp_sine),
      .out_cosine (rsp_cosine)
   );

   assign req_stall = !red_ready;

endmodule

/* hw/rtl/cordic_sc_reduce.sv */
module cordic_sc_reduce (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cordic_sc_pkg::angle_type in_angle,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cordic_sc_pkg::data_type  out_angle,
   output logic                    out_refl
);
   import cordic_sc_pkg::*;

   // Stage 0 forms the offset value, stages 1..QUOT_BITS each remove one quotient bit.
   localparam int NSTEP = QUOT_BITS + 1;

   logic     valid_ff [NSTEP];
   fold_type mode_ff [NSTEP];
   rem_type  rem_ff [NSTEP];
   logic [NSTEP:0] load;

   logic     fold_valid_ff;
   data_type fold_angle_ff;
   logic     fold_refl_ff;

   wide_type a_ext;
   wide_type pi_wide;
   wide_type u_pos;
   wide_type u_neg;
   wide_type u_pass;
   fold_type mode_in;
   rem_type  rem_in;

   assign in_ready = load[0];
   assign load[NSTEP] = !fold_valid_ff || out_ready;

   // Entry: classify the angle and form the value whose remainder is taken.
   assign a_ext = {in_angle[ANGLE_W-1], in_angle};
   assign pi_wide = wide_type'(PI_FX);
   assign u_pos = a_ext - pi_wide - 33'sd1;
   assign u_neg = -pi_wide - 33'sd1 - a_ext;
   assign u_pass = a_ext + pi_wide;

   always_comb begin
      if (a_ext > pi_wide) begin
         mode_in = FOLD_POS;
         rem_in = u_pos[REM_W-1:0];
      end else if (a_ext < -pi_wide) begin
         mode_in = FOLD_NEG;
         rem_in = u_neg[REM_W-1:0];
      end else begin
         mode_in = FOLD_PASS;
         rem_in = u_pass[REM_W-1:0];
      end
   end

   assign load[0] = !valid_ff[0] || load[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (load[0]) begin
         valid_ff[0] <= in_valid;
      end
      if (load[0]) begin
         mode_ff[0] <= mode_in;
         rem_ff[0] <= rem_in;
      end
   end

   // Restoring remainder steps by 2*pi, highest multiple first.
   for (genvar s = 1; s < NSTEP; s++) begin : g_step
      localparam logic [REM_W:0] STEP_SUB =
         (REM_W+1)'(TWO_PI_INT) << (QUOT_BITS - s);
      logic [REM_W:0] diff;
      logic           take;
      rem_type        step_rem_in;

      assign diff = {1'b0, rem_ff[s-1]} - STEP_SUB;
      assign take = (mode_ff[s-1] != FOLD_PASS) && !diff[REM_W];
      assign step_rem_in = take ? diff[REM_W-1:0] : rem_ff[s-1];
      assign load[s] = !valid_ff[s] || load[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (load[s]) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         if (load[s]) begin
            mode_ff[s] <= mode_ff[s-1];
            rem_ff[s] <= step_rem_in;
         end
      end
   end

   // Final stage: turn the remainder into [-pi, pi], then reflect into [-pi/2, pi/2].
   data_type r_ext;
   data_type wrap_angle;
   data_type fold_angle_in;
   logic     fold_refl_in;

   assign r_ext = data_type'({1'b0, rem_ff[NSTEP-1][PHASE_W-1:0]});

   always_comb begin
      case (mode_ff[NSTEP-1])
         FOLD_POS: wrap_angle = r_ext - PI_FX + 20'sd1;
         FOLD_NEG: wrap_angle = PI_FX - 20'sd1 - r_ext;
         default:  wrap_angle = r_ext - PI_FX;
      endcase
      if (wrap_angle < -HALF_PI) begin
         fold_angle_in = -PI_FX - wrap_angle;
         fold_refl_in = 1'b1;
      end else if (wrap_angle > HALF_PI) begin
         fold_angle_in = PI_FX - wrap_angle;
         fold_refl_in = 1'b1;
      end else begin
         fold_angle_in = wrap_angle;
         fold_refl_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (load[NSTEP]) begin
         fold_valid_ff <= valid_ff[NSTEP-1];
      end
      if (load[NSTEP]) begin
         fold_angle_ff <= fold_angle_in;
         fold_refl_ff <= fold_refl_in;
      end
   end

   assign out_valid = fold_valid_ff;
   assign out_angle = fold_angle_ff;
   assign out_refl = fold_refl_ff;

endmodule

/* hw/rtl/cordic_sc_rotate.sv */
module cordic_sc_rotate #(
   parameter int ITERATIONS = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cordic_sc_pkg::data_type  in_angle,
   input  logic                    in_refl,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cordic_sc_pkg::out_type   out_sine,
   output cordic_sc_pkg::out_type   out_cosine
);
   import cordic_sc_pkg::*;

   logic     valid_ff [ITERATIONS];
   data_type x_ff [ITERATIONS];
   data_type y_ff [ITERATIONS];
   data_type z_ff [ITERATIONS];
   logic     refl_ff [ITERATIONS];
   logic [ITERATIONS:0] load;

   logic     rsp_valid_ff;
   out_type  sine_ff;
   out_type  cosine_ff;

   assign in_ready = load[0];
   assign load[ITERATIONS] = !rsp_valid_ff || out_ready;

   // One rotation per stage, shift amount and arctangent fixed by position.
   for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
      logic     prev_valid;
      data_type x_prev;
      data_type y_prev;
      data_type z_prev;
      logic     refl_prev;
      data_type xs;
      data_type ys;
      data_type x_in;
      data_type y_in;
      data_type z_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign x_prev = INV_K;
         assign y_prev = '0;
         assign z_prev = in_angle;
         assign refl_prev = in_refl;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign x_prev = x_ff[k-1];
         assign y_prev = y_ff[k-1];
         assign z_prev = z_ff[k-1];
         assign refl_prev = refl_ff[k-1];
      end

      assign xs = x_prev >>> k;
      assign ys = y_prev >>> k;

      always_comb begin
         if (!z_prev[DATA_W-1]) begin
            x_in = x_prev - ys;
            y_in = y_prev + xs;
            z_in = z_prev - ATAN_TAB[k];
         end else begin
            x_in = x_prev + ys;
            y_in = y_prev - xs;
            z_in = z_prev + ATAN_TAB[k];
         end
      end

      assign load[k] = !valid_ff[k] || load[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (load[k]) begin
            valid_ff[k] <= prev_valid;
         end
         if (load[k]) begin
            x_ff[k] <= x_in;
            y_ff[k] <= y_in;
            z_ff[k] <= z_in;
            refl_ff[k] <= refl_prev;
         end
      end
   end

   // Output register: a reflected angle flips the sign of the cosine.
   data_type cos_full;
   out_type  sine_in;
   out_type  cosine_in;

   assign cos_full = refl_ff[ITERATIONS-1] ? -x_ff[ITERATIONS-1] : x_ff[ITERATIONS-1];
   assign sine_in = y_ff[ITERATIONS-1][OUT_W-1:0];
   assign cosine_in = cos_full[OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load[ITERATIONS]) begin
         rsp_valid_ff <= valid_ff[ITERATIONS-1];
      end
      if (load[ITERATIONS]) begin
         sine_ff <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_sine = sine_ff;
   assign out_cosine = cosine_ff;

endmodule
